// ===== design/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, codes and constant tables shared by the HTTP request head parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // Default sizes
  localparam int unsigned PATH_CAPACITY_DEF   = 64;
  localparam int unsigned HEAD_BUDGET_DEF     = 512;
  localparam int unsigned LINE_CAPACITY_DEF   = 64;
  localparam int unsigned METHOD_CAPACITY_DEF = 8;

  // Counter widths cover the full legal range of each size
  localparam int unsigned METHOD_CNT_W = 4;
  localparam int unsigned PATH_CNT_W   = 8;
  localparam int unsigned HEAD_CNT_W   = 16;
  localparam int unsigned LINE_POS_W   = 8;
  localparam int unsigned PATH_LEN_W   = 7;

  localparam int unsigned PREFIX_LEN   = 23;
  localparam int unsigned GET_LEN      = 3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  // Input actions
  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // Method status codes
  localparam logic [1:0] MS_GET     = 2'd0;
  localparam logic [1:0] MS_UNKNOWN = 2'd1;
  localparam logic [1:0] MS_CLOSED  = 2'd2;

  // Result kinds
  localparam logic KIND_PATH    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [7:0] GET_WORD [GET_LEN] = '{8'h47, 8'h45, 8'h54};

  // "If-None-Match: contentN"
  localparam logic [7:0] PREFIX_A [PREFIX_LEN] = '{
    8'h49, 8'h66, 8'h2D, 8'h4E, 8'h6F, 8'h6E, 8'h65, 8'h2D, 8'h4D, 8'h61, 8'h74, 8'h63,
    8'h68, 8'h3A, 8'h20, 8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h4E};

  // "Cache-Control: max-age="
  localparam logic [7:0] PREFIX_B [PREFIX_LEN] = '{
    8'h43, 8'h61, 8'h63, 8'h68, 8'h65, 8'h2D, 8'h43, 8'h6F, 8'h6E, 8'h74, 8'h72, 8'h6F,
    8'h6C, 8'h3A, 8'h20, 8'h6D, 8'h61, 8'h78, 8'h2D, 8'h61, 8'h67, 8'h65, 8'h3D};

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } hrhp_in_t;

  typedef struct packed {
    logic                  kind;
    logic [7:0]            path_byte;
    logic [1:0]            method_status;
    logic [PATH_LEN_W-1:0] path_length;
    logic                  path_cut_short;
    logic                  not_modified_seen;
    logic                  head_complete;
  } hrhp_out_t;

endpackage

// ===== design/http_request_head_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_head_parser
// Parses method, path and header lines of one request, one byte per beat.
// ----------------------------------------------------------------------------
// A result goes to the result register, or to the skid while out_data is stalled.
// Throughput: one input beat per cycle while in_stall is low; the parse state
// updates in a single pass of logic between the input and the result register.
// A two-entry output (result register plus skid) keeps in_stall registered.
// Reset (rst_n low, synchronous): parser returns to the method phase, outputs
// go idle.
module http_request_head_parser #(
  parameter int unsigned PathCapacity   = hrhp_pkg::PATH_CAPACITY_DEF,
  parameter int unsigned HeadBudget     = hrhp_pkg::HEAD_BUDGET_DEF,
  parameter int unsigned LineCapacity   = hrhp_pkg::LINE_CAPACITY_DEF,
  parameter int unsigned MethodCapacity = hrhp_pkg::METHOD_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrhp_pkg::hrhp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrhp_pkg::hrhp_out_t out_data
);
  import hrhp_pkg::*;

  localparam logic [METHOD_CNT_W-1:0] METHOD_CAP = METHOD_CNT_W'(MethodCapacity);
  localparam logic [PATH_CNT_W-1:0]   PATH_CAP   = PATH_CNT_W'(PathCapacity);
  localparam logic [HEAD_CNT_W-1:0]   HEAD_CAP   = HEAD_CNT_W'(HeadBudget);
  localparam logic [LINE_POS_W-1:0]   LINE_CAP   = LINE_POS_W'(LineCapacity);
  localparam logic [LINE_POS_W-1:0]   PREFIX_END = LINE_POS_W'(PREFIX_LEN);
  localparam logic [METHOD_CNT_W-1:0] GET_END    = METHOD_CNT_W'(GET_LEN);

  typedef enum logic [1:0] {
    PH_METHOD = 2'd0,
    PH_PATH   = 2'd1,
    PH_HEAD   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [METHOD_CNT_W-1:0] method_count_r, method_count_nxt;
  logic                    method_matches_r, method_matches_nxt;
  logic [1:0]              method_result_r, method_result_nxt;
  logic [PATH_CNT_W-1:0]   path_count_r, path_count_nxt;
  logic [HEAD_CNT_W-1:0]   head_count_r, head_count_nxt;
  logic [LINE_POS_W-1:0]   line_pos_r, line_pos_nxt;
  logic                    prefix_a_alive_r, prefix_a_alive_nxt;
  logic                    prefix_b_alive_r, prefix_b_alive_nxt;
  logic                    not_mod_r, not_mod_nxt;

  logic                    out_valid_r, skid_valid_r;
  hrhp_out_t               out_data_r, skid_data_r;

  logic                    in_accept, out_take;
  logic                    res_valid;
  hrhp_out_t               res;
  logic                    hit, complete;
  logic [7:0]              b;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.data_byte;

  always_comb begin
    phase_nxt          = phase_r;
    method_count_nxt   = method_count_r;
    method_matches_nxt = method_matches_r;
    method_result_nxt  = method_result_r;
    path_count_nxt     = path_count_r;
    head_count_nxt     = head_count_r;
    line_pos_nxt       = line_pos_r;
    prefix_a_alive_nxt = prefix_a_alive_r;
    prefix_b_alive_nxt = prefix_b_alive_r;
    not_mod_nxt        = not_mod_r;
    res_valid          = 1'b0;
    res                = '0;
    hit                = 1'b0;
    complete           = 1'b0;

    if (in_accept) begin
      unique case (in_data.action)
        ACT_START: begin
          phase_nxt          = PH_METHOD;
          method_count_nxt   = '0;
          method_matches_nxt = 1'b1;
          method_result_nxt  = MS_GET;
          path_count_nxt     = '0;
          head_count_nxt     = '0;
          line_pos_nxt       = '0;
          prefix_a_alive_nxt = 1'b1;
          prefix_b_alive_nxt = 1'b1;
          not_mod_nxt        = 1'b0;
        end
        ACT_CLOSE: begin
          if (phase_r != PH_DONE) begin
            res_valid              = 1'b1;
            res.kind               = KIND_SUMMARY;
            res.method_status      = method_result_r;
            res.path_length        = path_count_r[PATH_LEN_W-1:0];
            res.path_cut_short     = (phase_r == PH_PATH);
            res.not_modified_seen  = not_mod_r;
            res.head_complete      = 1'b0;
            if (phase_r == PH_METHOD) begin
              res.method_status     = MS_CLOSED;
              res.path_length       = '0;
              res.path_cut_short    = 1'b1;
              res.not_modified_seen = 1'b0;
            end
            phase_nxt = PH_DONE;
          end
        end
        ACT_DATA: begin
          unique case (phase_r)
            PH_METHOD: begin
              if (b == CHAR_SPACE) begin
                method_result_nxt = (method_matches_r && method_count_r == GET_END) ?
                                    MS_GET : MS_UNKNOWN;
                phase_nxt = PH_PATH;
              end else begin
                if (method_count_r >= GET_END) begin
                  method_matches_nxt = 1'b0;
                end else if (b != GET_WORD[method_count_r[1:0]]) begin
                  method_matches_nxt = 1'b0;
                end
                method_count_nxt = method_count_r + 1'b1;
                // method field full: close it as if a space came
                if (method_count_nxt >= METHOD_CAP) begin
                  method_result_nxt = (method_matches_nxt && method_count_nxt == GET_END) ?
                                      MS_GET : MS_UNKNOWN;
                  phase_nxt = PH_PATH;
                end
              end
            end
            PH_PATH: begin
              if (b == CHAR_SPACE) begin
                phase_nxt = PH_HEAD;
              end else begin
                path_count_nxt = path_count_r + 1'b1;
                if (path_count_nxt >= PATH_CAP) begin
                  phase_nxt = PH_HEAD;
                end
                res_valid     = 1'b1;
                res.kind      = KIND_PATH;
                res.path_byte = b;
              end
            end
            PH_HEAD: begin
              head_count_nxt = head_count_r + 1'b1;
              if (b == CHAR_LF) begin
                hit = (prefix_a_alive_r || prefix_b_alive_r) && (line_pos_r >= PREFIX_END);
                if (hit && !not_mod_r) begin
                  not_mod_nxt = 1'b1;
                end else if (line_pos_r == '0) begin
                  complete = 1'b1;
                end
                line_pos_nxt       = '0;
                prefix_a_alive_nxt = 1'b1;
                prefix_b_alive_nxt = 1'b1;
              end else begin
                // compare prefixes on the fly, first bytes of the line only
                if (line_pos_r < PREFIX_END) begin
                  if (b != PREFIX_A[line_pos_r[4:0]]) prefix_a_alive_nxt = 1'b0;
                  if (b != PREFIX_B[line_pos_r[4:0]]) prefix_b_alive_nxt = 1'b0;
                end
                if (line_pos_r < LINE_CAP) begin
                  line_pos_nxt = line_pos_r + 1'b1;
                end
              end
              if (complete || head_count_nxt >= HEAD_CAP) begin
                res_valid             = 1'b1;
                res.kind              = KIND_SUMMARY;
                res.method_status     = method_result_r;
                res.path_length       = path_count_r[PATH_LEN_W-1:0];
                res.path_cut_short    = 1'b0;
                res.not_modified_seen = not_mod_nxt;
                res.head_complete     = complete;
                phase_nxt             = PH_DONE;
              end
            end
            default: begin
              // drop bytes after the summary
            end
          endcase
        end
        default: begin
          // unused action code: ignore
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_METHOD;
      method_count_r   <= '0;
      method_matches_r <= 1'b1;
      method_result_r  <= MS_GET;
      path_count_r     <= '0;
      head_count_r     <= '0;
      line_pos_r       <= '0;
      prefix_a_alive_r <= 1'b1;
      prefix_b_alive_r <= 1'b1;
      not_mod_r        <= 1'b0;
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      method_count_r   <= method_count_nxt;
      method_matches_r <= method_matches_nxt;
      method_result_r  <= method_result_nxt;
      path_count_r     <= path_count_nxt;
      head_count_r     <= head_count_nxt;
      line_pos_r       <= line_pos_nxt;
      prefix_a_alive_r <= prefix_a_alive_nxt;
      prefix_b_alive_r <= prefix_b_alive_nxt;
      not_mod_r        <= not_mod_nxt;

      if (skid_valid_r) begin
        // drain the skid beat first; input is stalled meanwhile
        if (out_take) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (!out_valid_r || out_take) begin
        out_valid_r <= res_valid;
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_data_r <= skid_data_r;
    end else if (!out_valid_r || out_take) begin
      if (res_valid) out_data_r <= res;
    end else if (res_valid) begin
      skid_data_r <= res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while the result register is empty");

  a_summary_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_SUMMARY) |=> phase_r == PH_DONE)
    else $error("parser did not stop after its summary");

  a_path_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    path_count_r <= PATH_CAP)
    else $error("path count passed its capacity");

  a_budget_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (head_count_r <= HEAD_CAP) && (line_pos_r <= LINE_CAP))
    else $error("header counters out of range");

endmodule

// ===== verif/http_request_head_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_head_parser_test
// Sends request bytes through the parser with random gaps and stalls, predicts
// every path byte and summary beat in a scoreboard, and compares each result
// beat with the oldest prediction.
// ----------------------------------------------------------------------------

import hrhp_pkg::*;

localparam logic [1:0] ACT_UNUSED = 2'd3;

localparam logic [8*PREFIX_LEN-1:0] TAG_A = "If-None-Match: contentN";
localparam logic [8*PREFIX_LEN-1:0] TAG_B = "Cache-Control: max-age=";
// left-aligned so it indexes like the header tags
localparam logic [8*PREFIX_LEN-1:0] GET_TEXT = {"GET", {(8*(PREFIX_LEN-GET_LEN)){1'b0}}};

typedef enum logic [1:0] {PH_METHOD, PH_PATH, PH_HEADERS, PH_DONE} parse_phase_t;

function automatic logic [7:0] tag_char(logic [8*PREFIX_LEN-1:0] text, int idx);
  return text[8*(PREFIX_LEN-1-idx) +: 8];
endfunction

class head_parse_scoreboard;
  parse_phase_t phase;
  int           method_count;
  bit           method_ok;
  logic [1:0]   method_code;
  int           path_count;
  int           head_bytes;
  int           line_pos;
  bit           tag_a_live;
  bit           tag_b_live;
  bit           not_modified;
  hrhp_out_t    expected_results[$];
  int           mismatches;

  function new();
    clear();
    mismatches = 0;
  endfunction

  function void clear();
    phase = PH_METHOD;
    method_count = 0;
    method_ok = 1'b1;
    method_code = MS_GET;
    path_count = 0;
    head_bytes = 0;
    line_pos = 0;
    tag_a_live = 1'b1;
    tag_b_live = 1'b1;
    not_modified = 1'b0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void end_method();
    method_code = (method_ok && method_count == GET_LEN) ? MS_GET : MS_UNKNOWN;
    phase = PH_PATH;
  endfunction

  function void post_summary(bit complete, bit cut);
    hrhp_out_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.method_status = method_code;
    r.path_length = PATH_LEN_W'(path_count);
    r.path_cut_short = cut;
    r.not_modified_seen = not_modified;
    r.head_complete = complete;
    expected_results.push_back(r);
    phase = PH_DONE;
  endfunction

  function void note_beat(hrhp_in_t b);
    hrhp_out_t r;
    bit complete;
    r = '0;
    complete = 1'b0;
    if (b.action == ACT_START) begin
      clear();
      return;
    end
    if (b.action == ACT_UNUSED || phase == PH_DONE) return;
    if (b.action == ACT_CLOSE) begin
      if (phase == PH_METHOD) begin
        method_code = MS_CLOSED;
        path_count = 0;
        not_modified = 1'b0;
      end
      post_summary(1'b0, phase != PH_HEADERS);
      return;
    end
    case (phase)
      PH_METHOD: begin
        if (b.data_byte == CHAR_SPACE) begin
          end_method();
        end else begin
          if (method_count >= GET_LEN || b.data_byte != tag_char(GET_TEXT, method_count))
            method_ok = 1'b0;
          method_count++;
          if (method_count >= METHOD_CAPACITY_DEF) end_method();
        end
      end
      PH_PATH: begin
        if (b.data_byte == CHAR_SPACE) begin
          phase = PH_HEADERS;
        end else begin
          path_count++;
          if (path_count >= PATH_CAPACITY_DEF) phase = PH_HEADERS;
          r.kind = KIND_PATH;
          r.path_byte = b.data_byte;
          expected_results.push_back(r);
        end
      end
      default: begin
        head_bytes++;
        if (b.data_byte == CHAR_LF) begin
          // a tag line only counts the first time; after that it is an ordinary line
          if ((tag_a_live || tag_b_live) && line_pos >= PREFIX_LEN && !not_modified)
            not_modified = 1'b1;
          else if (line_pos == 0)
            complete = 1'b1;
          line_pos = 0;
          tag_a_live = 1'b1;
          tag_b_live = 1'b1;
        end else begin
          if (line_pos < PREFIX_LEN) begin
            if (b.data_byte != tag_char(TAG_A, line_pos)) tag_a_live = 1'b0;
            if (b.data_byte != tag_char(TAG_B, line_pos)) tag_b_live = 1'b0;
          end
          if (line_pos < LINE_CAPACITY_DEF) line_pos++;
        end
        if (complete || head_bytes >= HEAD_BUDGET_DEF) post_summary(complete, 1'b0);
      end
    endcase
  endfunction

  function string show(hrhp_out_t r);
    return $sformatf("kind %0d byte %h status %0d len %0d cut %0d nm %0d done %0d",
                     r.kind, r.path_byte, r.method_status, r.path_length,
                     r.path_cut_short, r.not_modified_seen, r.head_complete);
  endfunction

  function void check_result(hrhp_out_t got);
    hrhp_out_t want;
    bit bad;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: unexpected result beat: %s", $time, show(got));
      return;
    end
    want = expected_results.pop_front();
    bad = got.kind !== want.kind || got.path_byte !== want.path_byte ||
          got.method_status !== want.method_status ||
          got.path_length !== want.path_length ||
          got.path_cut_short !== want.path_cut_short ||
          got.not_modified_seen !== want.not_modified_seen ||
          got.head_complete !== want.head_complete;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch", $time);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endfunction
endclass

module http_request_head_parser_test;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hrhp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hrhp_out_t out_data;

  bit          hold_off = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          items_sent = 0;
  hrhp_in_t    plan[$];

  head_parse_scoreboard sb = new();

  http_request_head_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // note the input beat first: a result can never belong to a beat of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_beat(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  initial begin
    #5_000_000;
    $display("http_request_head_parser test failed");
    $finish;
  end

  function automatic hrhp_in_t make_beat(logic [1:0] act, logic [7:0] d);
    hrhp_in_t b;
    b.action = act;
    b.data_byte = d;
    return b;
  endfunction

  // any byte but the two delimiters
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CHAR_SPACE || c == CHAR_LF);
    return c;
  endfunction

  task automatic add_byte(logic [7:0] d);
    plan.push_back(make_beat(ACT_DATA, d));
  endtask

  task automatic add_method();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = GET_LEN;
      for (int i = 0; i < len; i++) add_byte(tag_char(GET_TEXT, i));
    end else if (pick < 82) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++)
        add_byte((i < GET_LEN && $urandom_range(3) != 0) ? tag_char(GET_TEXT, i) : text_byte());
    end else if (pick < 92) begin
      len = $urandom_range(0, METHOD_CAPACITY_DEF - 1);
      for (int i = 0; i < len; i++) add_byte(text_byte());
    end else begin
      len = METHOD_CAPACITY_DEF;
      for (int i = 0; i < len; i++) add_byte(text_byte());
    end
    if (len < METHOD_CAPACITY_DEF) add_byte(CHAR_SPACE);
  endtask

  task automatic add_path(int len);
    for (int i = 0; i < len; i++) begin
      if (i == 0 && $urandom_range(3) != 0) add_byte("/");
      else if ($urandom_range(19) == 0) add_byte(8'($urandom_range(255)));
      else add_byte(text_byte());
    end
    // a space after a full path lands in the headers
    if (len < PATH_CAPACITY_DEF || $urandom_range(1) == 0) add_byte(CHAR_SPACE);
  endtask

  // one non-empty header line, LF included
  task automatic add_line();
    int pick;
    int len;
    int cut;
    logic [8*PREFIX_LEN-1:0] tag;
    pick = $urandom_range(99);
    tag = $urandom_range(1) ? TAG_A : TAG_B;
    if (pick < 45) begin
      for (int i = 0; i < PREFIX_LEN; i++) add_byte(tag_char(tag, i));
      len = $urandom_range(0, 6);
    end else if (pick < 60) begin
      cut = $urandom_range(0, PREFIX_LEN - 1);
      for (int i = 0; i < cut; i++) add_byte(tag_char(tag, i));
      add_byte(tag_char(tag, cut) ^ 8'h01);
      len = $urandom_range(0, 10);
    end else if (pick < 90) begin
      len = $urandom_range(1, 20);
    end else begin
      len = $urandom_range(21, 80);
    end
    for (int i = 0; i < len; i++) add_byte(text_byte());
    add_byte(CHAR_LF);
  endtask

  task automatic build_directed();
    plan.delete();
    // empty method, then close in the path
    plan.push_back(make_beat(ACT_START, 8'h00));
    add_byte(CHAR_SPACE);
    plan.push_back(make_beat(ACT_CLOSE, 8'hFF));
    // close while still in the method
    plan.push_back(make_beat(ACT_START, 8'hFF));
    plan.push_back(make_beat(ACT_CLOSE, 8'h00));
    // method fills up, close right after
    plan.push_back(make_beat(ACT_START, 8'h00));
    repeat (METHOD_CAPACITY_DEF) add_byte(text_byte());
    plan.push_back(make_beat(ACT_CLOSE, 8'h00));
    // GET with extreme path bytes and an empty first header line
    plan.push_back(make_beat(ACT_START, 8'h00));
    for (int i = 0; i < GET_LEN; i++) add_byte(tag_char(GET_TEXT, i));
    add_byte(CHAR_SPACE);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CHAR_SPACE);
    add_byte(CHAR_LF);
    // all dropped after the summary
    add_byte(8'h00);
    plan.push_back(make_beat(ACT_CLOSE, 8'hFF));
    plan.push_back(make_beat(ACT_UNUSED, 8'hFF));
  endtask

  task automatic build_request();
    int pick;
    int method_end;
    int path_end;
    int lo;
    int hi;
    int cut_at;
    plan.delete();
    plan.push_back(make_beat(ACT_START, text_byte()));
    add_method();
    method_end = plan.size();
    pick = $urandom_range(99);
    if (pick < 5) add_path(0);
    else if (pick < 85) add_path($urandom_range(1, 16));
    else if (pick < 95) add_path(PATH_CAPACITY_DEF);
    else add_path(PATH_CAPACITY_DEF - 1);
    path_end = plan.size();
    repeat ($urandom_range(0, 3)) add_line();
    if ($urandom_range(9) != 0) add_byte(CHAR_LF);
    pick = $urandom_range(99);
    if (pick < 25) begin
      // close part-way through one of the three sections
      case ($urandom_range(2))
        0: begin lo = 1; hi = method_end - 1; end
        1: begin lo = method_end; hi = path_end - 1; end
        default: begin lo = path_end; hi = plan.size() - 1; end
      endcase
      cut_at = (hi >= lo) ? int'($urandom_range(lo, hi)) : plan.size();
      while (plan.size() > cut_at) void'(plan.pop_back());
      plan.push_back(make_beat(ACT_CLOSE, text_byte()));
    end else if (pick < 30) begin
      plan.push_back(make_beat(ACT_CLOSE, text_byte()));
    end
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(1, 3))
        plan.push_back(make_beat(2'($urandom_range(3)), 8'($urandom_range(255))));
  endtask

  // fills the header budget; optionally the budget byte is the blank line itself
  task automatic build_budget_request(bit blank_end, int plen);
    int used;
    int left;
    int size_was;
    plan.delete();
    plan.push_back(make_beat(ACT_START, 8'h00));
    for (int i = 0; i < GET_LEN; i++) add_byte(tag_char(GET_TEXT, i));
    add_byte(CHAR_SPACE);
    for (int i = 0; i < plen; i++) add_byte(text_byte());
    if (plen < PATH_CAPACITY_DEF) add_byte(CHAR_SPACE);
    used = 0;
    while (used < HEAD_BUDGET_DEF - 100) begin
      size_was = plan.size();
      add_line();
      used += plan.size() - size_was;
    end
    left = HEAD_BUDGET_DEF - used;
    if (blank_end) begin
      repeat (left - 2) add_byte(text_byte());
      add_byte(CHAR_LF);
      add_byte(CHAR_LF);
    end else begin
      repeat (left + $urandom_range(1, 8)) add_byte(text_byte());
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0; recv_stall_pct <= 0; end
      1: begin send_idle_pct = 46; recv_stall_pct <= 0; end
      2: begin send_idle_pct = 0; recv_stall_pct <= 46; end
      default: begin send_idle_pct = 33; recv_stall_pct <= 33; end
    endcase
  endtask

  // entered and left just after a falling edge
  task automatic send_beat(hrhp_in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_plan();
    foreach (plan[i]) send_beat(plan[i]);
    items_sent += plan.size();
  endtask

  task automatic hold_receiver(int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(negedge clk);
    hold_off <= 1'b0;
  endtask

  initial begin
    int req_no;
    int drain;
    req_no = 0;
    drain = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    build_directed();
    send_plan();

    // hold the result side while a long path streams in, so the input backs up
    set_idling(0);
    build_budget_request(1'b1, PATH_CAPACITY_DEF);
    fork
      hold_receiver(200);
      send_plan();
    join

    while (items_sent < 1200) begin
      set_idling(req_no % 4);
      if ($urandom_range(59) == 0)
        build_budget_request(1'($urandom_range(1)), $urandom_range(1, PATH_CAPACITY_DEF));
      else
        build_request();
      send_plan();
      req_no++;
    end
    in_valid = 1'b0;

    while (sb.pending() != 0 && drain < 2000) begin
      @(negedge clk);
      drain++;
    end
    repeat (4) @(negedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("http_request_head_parser test passed");
    end else begin
      $display("http_request_head_parser test failed");
    end
    $finish;
  end

endmodule
